// ----- design/assert_macros.svh -----
// Assertion macros for the checker file of the digit conversion unit.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, masked while reset is asserted
`define SIRD_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define SIRD_ASSERT_NR(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/sird_pkg.sv -----
// Shared types, constants and lookup functions for the radix digit converter.
// No dependencies.
`default_nettype none

package sird_pkg;

	localparam int unsigned MAX_SYMBOLS_DEF = 16;
	localparam int unsigned SYM_COUNT       = 16;
	localparam int unsigned SYM_IDX_W       = 4;
	localparam int unsigned LEN_W           = 5;
	localparam int unsigned VALUE_W         = 32;
	localparam int unsigned CHAR_W          = 8;
	localparam int unsigned CFG_DATA_W      = 64;
	localparam int unsigned CFG_IDX_W       = 2;
	localparam int unsigned STACK_DEPTH     = 32;
	localparam int unsigned STACK_IDX_W     = 5;
	localparam int unsigned DCNT_W          = 6;
	localparam int unsigned QUEUE_DEPTH     = 2;

	localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

	localparam logic [CFG_IDX_W-1:0] REG_BASE_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_LOW = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

	localparam logic [LEN_W-1:0]      RST_BASE_LENGTH = 5'd10;
	localparam logic [CFG_DATA_W-1:0] RST_SYMBOLS_LOW = 64'h3736_3534_3332_3130;
	localparam logic [CFG_DATA_W-1:0] RST_SYMBOLS_HIGH = 64'h0000_0000_0000_3938;

	typedef struct packed {
		logic [LEN_W-1:0]                len;
		logic [SYM_COUNT*CHAR_W-1:0]     symbols;
	} cfg_t;

	typedef struct packed {
		logic               neg;
		logic [VALUE_W-1:0] mag;
	} item_t;

	function automatic logic [CHAR_W-1:0] sym_of(input logic [SYM_COUNT*CHAR_W-1:0] symbols,
			input logic [SYM_IDX_W-1:0] idx);
		sym_of = symbols[{idx, 3'b000} +: CHAR_W];
	endfunction

	// floor(2^32 / len) for each legal radix
	function automatic logic [VALUE_W-1:0] recip_of(input logic [LEN_W-1:0] len);
		logic [VALUE_W-1:0] r;
		unique case (len)
			5'd2:    r = 32'd2147483648;
			5'd3:    r = 32'd1431655765;
			5'd4:    r = 32'd1073741824;
			5'd5:    r = 32'd858993459;
			5'd6:    r = 32'd715827882;
			5'd7:    r = 32'd613566756;
			5'd8:    r = 32'd536870912;
			5'd9:    r = 32'd477218588;
			5'd10:   r = 32'd429496729;
			5'd11:   r = 32'd390451572;
			5'd12:   r = 32'd357913941;
			5'd13:   r = 32'd330382099;
			5'd14:   r = 32'd306783378;
			5'd15:   r = 32'd286331153;
			5'd16:   r = 32'd268435456;
			default: r = '0;
		endcase
		recip_of = r;
	endfunction

endpackage

`default_nettype wire

// ----- design/sird_front.sv -----
// Front end: accepts input words, checks the alphabet and splits sign and magnitude.
// Depends on sird_pkg.
`default_nettype none

module sird_front #(
	parameter int unsigned MAX_SYMBOLS = sird_pkg::MAX_SYMBOLS_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                in_valid,
	output logic                               in_stall,
	input  wire signed [sird_pkg::VALUE_W-1:0] value,
	input  sird_pkg::cfg_t                     cfg,
	input  wire                                q_full,
	output logic                               push,
	output sird_pkg::item_t                    push_item
);
	import sird_pkg::*;

	logic        valid_s1;
	logic        ok_s1;
	item_t       item_s1;
	logic        ok;
	logic        accept;
	logic        neg;
	logic [VALUE_W-1:0] raw;

	// alphabet check: radix range, no sign symbols, all symbols distinct
	always_comb begin
		logic [CHAR_W-1:0] si;
		ok = (cfg.len >= 5'd2) && (cfg.len <= LEN_W'(MAX_SYMBOLS));
		for (int i = 0; i < SYM_COUNT; i++) begin
			si = sym_of(cfg.symbols, SYM_IDX_W'(i));
			if (LEN_W'(i) < cfg.len) begin
				if (si == CHAR_PLUS || si == CHAR_MINUS)
					ok = 1'b0;
				for (int j = i + 1; j < SYM_COUNT; j++) begin
					if (LEN_W'(j) < cfg.len && sym_of(cfg.symbols, SYM_IDX_W'(j)) == si)
						ok = 1'b0;
				end
			end
		end
	end

	assign raw      = unsigned'(value);
	assign neg      = raw[VALUE_W-1];
	assign push     = valid_s1 && ok_s1 && !q_full;
	assign in_stall = valid_s1 && ok_s1 && q_full;
	assign accept   = in_valid && !in_stall;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (valid_s1 && (!ok_s1 || !q_full)) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ok_s1       <= ok;
			item_s1.neg <= neg;
			item_s1.mag <= neg ? (VALUE_W'(0) - raw) : raw;
		end
	end

endmodule

`default_nettype wire

// ----- design/sird_queue.sv -----
// Short FIFO between the front end and the digit engine.
// Depends on sird_pkg.
`default_nettype none

module sird_queue (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	input  sird_pkg::item_t  push_item,
	input  wire              pop,
	output sird_pkg::item_t  head,
	output logic             full,
	output logic             empty
);
	import sird_pkg::*;

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t              mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign full    = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_item;
	end

endmodule

`default_nettype wire

// ----- design/sird_back.sv -----
// Digit engine: reciprocal-multiply division per digit into a digit stack,
// then emits sign and symbols through an output register. Depends on sird_pkg.
`default_nettype none

module sird_back #(
	parameter int unsigned MAX_SYMBOLS = sird_pkg::MAX_SYMBOLS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  sird_pkg::cfg_t               cfg,
	input  wire                          q_empty,
	input  sird_pkg::item_t              head,
	output logic                         pop,
	output logic                         out_valid,
	input  wire                          out_stall,
	output logic [sird_pkg::CHAR_W-1:0]  character,
	output logic                         final_char
);
	import sird_pkg::*;

	localparam int unsigned DIG_W = $clog2(MAX_SYMBOLS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_MLEN,
		ST_FIX,
		ST_SIGN,
		ST_DIGIT
	} state_t;

	state_t                   state_q;
	logic [VALUE_W-1:0]       mag_q;
	logic                     neg_q;
	logic [VALUE_W-1:0]       qest_q;
	logic [VALUE_W-1:0]       qlen_q;
	logic [DCNT_W-1:0]        nd_q;
	logic [STACK_IDX_W-1:0]   rd_q;
	logic [DIG_W-1:0]         stack_q [STACK_DEPTH];
	logic                     out_valid_q;
	logic [CHAR_W-1:0]        char_q;
	logic                     final_q;

	logic [2*VALUE_W-1:0]     prod;
	logic [VALUE_W+LEN_W-1:0] qlen_full;
	logic [VALUE_W-1:0]       rem;
	logic                     over;
	logic [VALUE_W-1:0]       rem_fix;
	logic [VALUE_W-1:0]       quot;
	logic                     out_load;
	logic                     emit;

	assign prod      = (2*VALUE_W)'(mag_q) * (2*VALUE_W)'(recip_of(cfg.len));
	assign qlen_full = (VALUE_W+LEN_W)'(qest_q) * (VALUE_W+LEN_W)'(cfg.len);
	// estimate is low by at most one, a single correction step suffices
	assign rem       = mag_q - qlen_q;
	assign over      = rem >= VALUE_W'(cfg.len);
	assign rem_fix   = over ? rem - VALUE_W'(cfg.len) : rem;
	assign quot      = over ? qest_q + 1'b1 : qest_q;
	assign out_load  = !out_valid_q || !out_stall;
	assign emit      = ((state_q == ST_SIGN) || (state_q == ST_DIGIT)) && out_load;

	assign pop        = (state_q == ST_IDLE) && !q_empty;
	assign out_valid  = out_valid_q;
	assign character  = char_q;
	assign final_char = final_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (emit)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty)
						state_q <= ST_MUL;
				end
				ST_MUL:  state_q <= ST_MLEN;
				ST_MLEN: state_q <= ST_FIX;
				ST_FIX: begin
					if (quot != '0)
						state_q <= ST_MUL;
					else
						state_q <= neg_q ? ST_SIGN : ST_DIGIT;
				end
				ST_SIGN: begin
					if (out_load)
						state_q <= ST_DIGIT;
				end
				ST_DIGIT: begin
					if (out_load && rd_q == '0)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				mag_q <= head.mag;
				neg_q <= head.neg;
				nd_q  <= '0;
			end
			ST_MUL:  qest_q <= prod[2*VALUE_W-1:VALUE_W];
			ST_MLEN: qlen_q <= qlen_full[VALUE_W-1:0];
			ST_FIX: begin
				stack_q[nd_q[STACK_IDX_W-1:0]] <= rem_fix[DIG_W-1:0];
				nd_q  <= nd_q + 1'b1;
				mag_q <= quot;
				rd_q  <= nd_q[STACK_IDX_W-1:0];
			end
			ST_SIGN: begin
				if (out_load) begin
					char_q  <= CHAR_MINUS;
					final_q <= 1'b0;
				end
			end
			ST_DIGIT: begin
				if (out_load) begin
					char_q  <= sym_of(cfg.symbols, SYM_IDX_W'(stack_q[rd_q]));
					final_q <= (rd_q == '0);
					rd_q    <= rd_q - 1'b1;
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// ----- design/signed_int_to_radix_digits_unit.sv -----
// Signed 32-bit integer to text in a configurable radix, most significant digit first.
// Accepted words pass the front-end register and the queue; the digit engine divides
// out every digit (states MUL, MLEN, FIX) before the first character, then emits one
// character per cycle while not stalled. Front end and queue take words meanwhile.
// Reset: arst_n clears all control state; config returns to radix 10 with digits 0-9.
// Depends on sird_pkg, sird_front, sird_queue, sird_back.
`default_nettype none

module signed_int_to_radix_digits_unit #(
	parameter int unsigned MAX_SYMBOLS = sird_pkg::MAX_SYMBOLS_DEF
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   in_valid,
	output logic                                  in_stall,
	input  wire signed [sird_pkg::VALUE_W-1:0]    value,
	output logic                                  out_valid,
	input  wire                                   out_stall,
	output logic [sird_pkg::CHAR_W-1:0]           character,
	output logic                                  final_char,
	input  wire                                   cfg_valid,
	output logic                                  cfg_ready,
	input  wire [sird_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire [sird_pkg::CFG_DATA_W-1:0]        cfg_data
);
	import sird_pkg::*;

	logic [LEN_W-1:0]      base_length_q;
	logic [CFG_DATA_W-1:0] sym_low_q;
	logic [CFG_DATA_W-1:0] sym_high_q;
	cfg_t                  cfg;
	logic                  q_full;
	logic                  q_empty;
	logic                  push;
	logic                  pop;
	item_t                 push_item;
	item_t                 head;

	assign cfg_ready   = 1'b1;
	assign cfg.len     = base_length_q;
	assign cfg.symbols = {sym_high_q, sym_low_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_length_q <= RST_BASE_LENGTH;
			sym_low_q     <= RST_SYMBOLS_LOW;
			sym_high_q    <= RST_SYMBOLS_HIGH;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_BASE_LENGTH:  base_length_q <= cfg_data[LEN_W-1:0];
				REG_SYMBOLS_LOW:  sym_low_q     <= cfg_data;
				REG_SYMBOLS_HIGH: sym_high_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	sird_front #(
		.MAX_SYMBOLS (MAX_SYMBOLS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.value     (value),
		.cfg       (cfg),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	sird_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.full      (q_full),
		.empty     (q_empty)
	);

	sird_back #(
		.MAX_SYMBOLS (MAX_SYMBOLS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.q_empty    (q_empty),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.character  (character),
		.final_char (final_char)
	);

endmodule

`default_nettype wire

// ----- design/sird_checker.sv -----
// Port-level checker for the radix digit converter, bound to the top level.
// Depends on sird_pkg and assert_macros.svh.
`include "assert_macros.svh"
`default_nettype none

module sird_checker (
	input wire                           clk,
	input wire                           arst_n,
	input wire                           out_valid,
	input wire                           out_stall,
	input wire [sird_pkg::CHAR_W-1:0]    character,
	input wire                           final_char
);
	import sird_pkg::*;

	`SIRD_ASSERT_NR(a_rst_no_out, clk, !arst_n |-> !out_valid, "output word valid during reset")
	`SIRD_ASSERT(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid, "stalled output word dropped")
	`SIRD_ASSERT(a_out_stable, clk, arst_n, out_valid && out_stall |=> $stable(character) && $stable(final_char), "stalled output word changed")
	// a minus sign is always followed by at least one digit
	`SIRD_ASSERT(a_sign_not_last, clk, arst_n, out_valid && character == CHAR_MINUS |-> !final_char, "sign flagged as last character")

endmodule

bind signed_int_to_radix_digits_unit sird_checker u_sird_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.character  (character),
	.final_char (final_char)
);

`default_nettype wire

// ----- tb/sv/signed_int_to_radix_digits_unit_test.sv -----
// Self-checking testbench for signed_int_to_radix_digits_unit: directed table, then random
// phases under changing radix and alphabet settings, with random idling on both channels.
// Depends on sird_pkg and the unit itself.
`default_nettype none

module signed_int_to_radix_digits_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import sird_pkg::*;

	localparam int unsigned MAX_SYMBOLS   = sird_pkg::MAX_SYMBOLS_DEF;
	localparam int unsigned TOTAL_ITEMS   = 260;
	localparam int unsigned SETTLE_CYCLES = 250;
	localparam int unsigned LONG_HOLD     = 400;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	localparam logic [63:0] DEC_LOW  = 64'h3736_3534_3332_3130;
	localparam logic [63:0] DEC_HIGH = 64'h0000_0000_0000_3938;
	localparam logic [63:0] HEX_HIGH = 64'h6665_6463_6261_3938;

	typedef struct packed {
		logic [CHAR_W-1:0] character;
		logic              last;
	} text_char_t;

	typedef enum logic [1:0] {ROW_WRITE, ROW_VALUE} row_kind_t;

	typedef struct {
		row_kind_t              kind;
		logic [CFG_IDX_W-1:0]   idx;
		logic [CFG_DATA_W-1:0]  data;
		logic [VALUE_W-1:0]     val;
		bit                     typed;
		string                  text;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic signed [VALUE_W-1:0] value;
	logic out_valid;
	logic out_stall;
	logic [CHAR_W-1:0] character;
	logic final_char;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// mirror of the block's configuration
	logic [LEN_W-1:0] cur_radix;
	logic [2*CFG_DATA_W-1:0] cur_symbols;

	text_char_t char_queue[$];
	stim_row_t rows[$];

	int unsigned mismatches;
	int unsigned chars_seen;
	int unsigned items_sent;
	int unsigned counted_items;
	int unsigned writes_done;
	int unsigned phases;
	int unsigned hold_requests;

	signed_int_to_radix_digits_unit #(
		.MAX_SYMBOLS(MAX_SYMBOLS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.value(value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.character(character),
		.final_char(final_char),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("timeout: %0d characters still pending", char_queue.size());
		$display("** signed_int_to_radix_digits_unit: FAILED **");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	function automatic logic [CHAR_W-1:0] symbol_at(input int d);
		return cur_symbols[d*8 +: 8];
	endfunction

	function automatic bit alphabet_usable(input logic [LEN_W-1:0] radix);
		int i;
		int j;
		if (radix < 2 || radix > MAX_SYMBOLS)
			return 1'b0;
		for (i = 0; i < radix; i++) begin
			if (symbol_at(i) == CHAR_PLUS || symbol_at(i) == CHAR_MINUS)
				return 1'b0;
			for (j = i + 1; j < radix; j++)
				if (symbol_at(j) == symbol_at(i))
					return 1'b0;
		end
		return 1'b1;
	endfunction

	// queues the text of raw in the current radix; returns the number of characters
	function automatic int convert_to_text(input logic [VALUE_W-1:0] raw);
		logic neg;
		logic [VALUE_W-1:0] mag;
		int digs[32];
		int nd;
		int k;
		if (!alphabet_usable(cur_radix))
			return 0;
		neg = raw[VALUE_W-1];
		mag = neg ? (32'd0 - raw) : raw;
		nd = 0;
		do begin
			digs[nd] = int'(mag % cur_radix);
			mag = mag / cur_radix;
			nd++;
		end while (mag != 0 && nd < 32);
		if (neg)
			char_queue.push_back('{character: CHAR_MINUS, last: 1'b0});
		for (k = nd - 1; k >= 0; k--)
			char_queue.push_back('{character: symbol_at(digs[k]), last: (k == 0)});
		return nd + (neg ? 1 : 0);
	endfunction

	function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		stim_row_t r;
		r.kind = ROW_WRITE;
		r.idx = idx;
		r.data = data;
		r.val = '0;
		r.typed = 1'b0;
		r.text = "";
		rows.push_back(r);
	endfunction

	function automatic void add_value(input logic [VALUE_W-1:0] v, input bit typed,
			input string text);
		stim_row_t r;
		r.kind = ROW_VALUE;
		r.idx = '0;
		r.data = '0;
		r.val = v;
		r.typed = typed;
		r.text = text;
		rows.push_back(r);
	endfunction

	function automatic int unsigned pick_gap(input bit no_gaps);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [VALUE_W-1:0] random_value();
		int unsigned r;
		logic [VALUE_W-1:0] v;
		r = $urandom_range(0, 99);
		if (r < 30) begin
			v = $urandom;
		end else if (r < 50) begin
			v = $urandom_range(0, 100);
		end else if (r < 65) begin
			v = $urandom_range(0, 1000000);
		end else if (r < 75) begin
			case ($urandom_range(0, 6))
				0: v = 32'h0000_0000;
				1: v = 32'hFFFF_FFFF;
				2: v = 32'h0000_0001;
				3: v = 32'h8000_0000;
				4: v = 32'h7FFF_FFFF;
				5: v = 32'h8000_0001;
				default: v = 32'h7FFF_FFFE;
			endcase
		end else begin
			v = $urandom >> $urandom_range(0, 31);
		end
		if (r >= 30 && r < 65 && $urandom_range(0, 1) == 1)
			v = 32'd0 - v;
		return v;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_BASE_LENGTH:  cur_radix = data[LEN_W-1:0];
			REG_SYMBOLS_LOW:  cur_symbols[63:0] = data;
			REG_SYMBOLS_HIGH: cur_symbols[127:64] = data;
			default: ;
		endcase
		writes_done++;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// items with an unusable alphabet give no output, so allow the block time to finish them
	task automatic settle_idle();
		while (char_queue.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// returns the number of characters the word should produce
	task automatic send_value(input logic [VALUE_W-1:0] v, input int unsigned gap,
			input bit typed, input string text, output int produced);
		int k;
		in_valid <= 1'b1;
		value <= v;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
		if (typed) begin
			for (k = 0; k < text.len(); k++)
				char_queue.push_back('{character: text[k], last: (k == text.len() - 1)});
			produced = text.len();
		end else begin
			produced = convert_to_text(v);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// usable_only keeps the setting convertible, for phases that must produce output
	task automatic pick_setting(input bit usable_only,
			output logic [CFG_DATA_W-1:0] len_word,
			output logic [2*CFG_DATA_W-1:0] alpha);
		int unsigned kind;
		int unsigned len;
		int unsigned i;
		int unsigned j;
		logic [7:0] b;
		bit taken[256];
		kind = usable_only ? $urandom_range(0, 6) : $urandom_range(0, 9);
		for (i = 0; i < 16; i++) begin
			do
				b = $urandom_range(0, 255);
			while (taken[b] || b == CHAR_PLUS || b == CHAR_MINUS);
			taken[b] = 1'b1;
			alpha[i*8 +: 8] = b;
		end
		i = $urandom_range(0, 9);
		len = (i < 2) ? 2 : (i < 4) ? 16 : $urandom_range(3, 15);
		if (kind == 7) begin
			// spoil a usable alphabet: a repeat or a sign symbol inside the radix
			i = $urandom_range(0, len - 2);
			j = $urandom_range(i + 1, len - 1);
			case ($urandom_range(0, 2))
				0: alpha[j*8 +: 8] = alpha[i*8 +: 8];
				1: alpha[i*8 +: 8] = CHAR_PLUS;
				default: alpha[j*8 +: 8] = CHAR_MINUS;
			endcase
		end else if (kind == 8) begin
			alpha = {$urandom, $urandom, $urandom, $urandom};
			len = $urandom_range(0, 31);
		end else if (kind == 9) begin
			len = $urandom_range(0, 16);
			len = (len < 2) ? len : len + 15;
		end
		len_word = {$urandom, $urandom};
		len_word[LEN_W-1:0] = len[LEN_W-1:0];
	endtask

	initial begin : stimulus
		int i;
		int k;
		int n;
		int produced;
		int unsigned gap;
		bit no_gaps;
		bit pause;
		logic [CFG_DATA_W-1:0] len_word;
		logic [2*CFG_DATA_W-1:0] alpha;

		arst_n = 1'b0;
		in_valid <= 1'b0;
		value <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		cur_radix = RST_BASE_LENGTH;
		cur_symbols = {RST_SYMBOLS_HIGH, RST_SYMBOLS_LOW};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setting, decimal
		add_value(32'h0000_0000, 1'b1, "0");
		add_value(32'h7FFF_FFFF, 1'b1, "2147483647");
		add_value(32'h8000_0000, 1'b1, "-2147483648");
		add_value(32'hFFFF_FFFF, 1'b1, "-1");
		add_value(32'd9, 1'b1, "9");
		add_value(-32'sd10, 1'b1, "-10");
		add_value(32'd1234567, 1'b0, "");
		// binary, upper bits of the length word set
		add_write(REG_BASE_LENGTH, 64'hFFFF_FFFF_FFFF_FFE2);
		add_value(32'h8000_0000, 1'b0, "");
		add_value(32'h7FFF_FFFF, 1'b0, "");
		add_value(32'd5, 1'b1, "101");
		// hex
		add_write(REG_BASE_LENGTH, 64'd16);
		add_write(REG_SYMBOLS_HIGH, HEX_HIGH);
		add_value(32'h7FFF_FFFF, 1'b1, "7fffffff");
		add_value(32'h8000_0000, 1'b1, "-80000000");
		add_value(32'hDEAD_BEEF, 1'b0, "");
		// radix out of range
		add_write(REG_BASE_LENGTH, 64'd1);
		add_value(32'd5, 1'b1, "");
		add_write(REG_BASE_LENGTH, 64'hFFFF_FFFF_FFFF_FFE0);
		add_value(-32'sd3, 1'b1, "");
		add_write(REG_BASE_LENGTH, 64'd17);
		add_value(32'd100, 1'b1, "");
		add_write(REG_BASE_LENGTH, 64'hFFFF_FFFF_FFFF_FFFF);
		add_value(-32'sd100, 1'b1, "");
		// sign symbols in the alphabet
		add_write(REG_BASE_LENGTH, 64'd16);
		add_write(REG_SYMBOLS_HIGH, 64'h2D65_6463_6261_3938);
		add_value(32'd255, 1'b1, "");
		add_write(REG_SYMBOLS_HIGH, 64'h2B65_6463_6261_3938);
		add_value(32'd255, 1'b1, "");
		// the '+' now sits beyond the radix and is ignored
		add_write(REG_BASE_LENGTH, 64'd15);
		add_value(32'd255, 1'b0, "");
		// repeated symbols, apart and adjacent
		add_write(REG_BASE_LENGTH, 64'd16);
		add_write(REG_SYMBOLS_HIGH, HEX_HIGH);
		add_write(REG_SYMBOLS_LOW, 64'h3736_3534_3332_3139);
		add_value(32'd7, 1'b1, "");
		add_write(REG_BASE_LENGTH, 64'd2);
		add_write(REG_SYMBOLS_LOW, 64'h0);
		add_value(32'd1, 1'b1, "");
		// zero byte is an ordinary symbol
		add_write(REG_SYMBOLS_LOW, 64'h0000_0000_0000_0100);
		add_value(32'd2, 1'b0, "");
		add_write(REG_SYMBOLS_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
		add_value(32'hFFFF_FFFF, 1'b1, "");
		// spare index must not disturb anything
		add_write(REG_SPARE, 64'h2B2D_2B2D_2B2D_2B2D);
		add_write(REG_BASE_LENGTH, 64'd10);
		add_write(REG_SYMBOLS_LOW, DEC_LOW);
		add_write(REG_SYMBOLS_HIGH, DEC_HIGH);
		add_value(-32'sd987654321, 1'b0, "");

		for (i = 0; i < rows.size(); i++) begin
			if (rows[i].kind == ROW_WRITE) begin
				if (i > 0 && rows[i-1].kind == ROW_VALUE)
					settle_idle();
				write_reg(rows[i].idx, rows[i].data);
			end else begin
				gap = pick_gap(1'b0);
				if ((i == rows.size() - 1 || rows[i+1].kind == ROW_WRITE) && gap == 0)
					gap = 1;
				send_value(rows[i].val, gap, rows[i].typed, rows[i].text, produced);
			end
		end

		// random phases, each under a fresh setting
		while (items_sent < TOTAL_ITEMS) begin
			phases++;
			settle_idle();
			pick_setting(phases == 3 || phases == 5, len_word, alpha);
			write_reg(REG_SYMBOLS_LOW, alpha[63:0]);
			write_reg(REG_SYMBOLS_HIGH, alpha[127:64]);
			write_reg(REG_BASE_LENGTH, len_word);
			n = $urandom_range(10, 40);
			no_gaps = ($urandom_range(0, 3) == 0);
			if (phases == 3) begin
				// receiver goes quiet while words keep coming
				no_gaps = 1'b1;
				hold_requests++;
			end
			for (k = 0; k < n; k++) begin
				gap = pick_gap(no_gaps);
				pause = (phases == 5 && k == n / 2);
				if ((k == n - 1 || pause) && gap == 0)
					gap = 1;
				send_value(random_value(), gap, 1'b0, "", produced);
				if (produced > 0)
					counted_items++;
				if (pause)
					while (char_queue.size() != 0)
						@(posedge clk);
			end
		end

		while (char_queue.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d words (%0d converted in random phases), %0d characters checked",
			items_sent, counted_items, chars_seen);
		$display("%0d register writes over %0d random settings, mismatches: %0d",
			writes_done, phases, mismatches);
		if (mismatches == 0)
			$display("** signed_int_to_radix_digits_unit: PASSED **");
		else
			$display("** signed_int_to_radix_digits_unit: FAILED **");
		$finish;
	end

	initial begin : receiver
		int unsigned run_left;
		int unsigned hold_left;
		int unsigned hold_taken;
		int unsigned r;
		logic run_level;
		run_left = 0;
		hold_left = 0;
		hold_taken = 0;
		run_level = 1'b0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_taken != hold_requests) begin
				hold_taken = hold_requests;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				if (run_left == 0) begin
					r = $urandom_range(0, 99);
					if (r < 50) begin
						run_level = 1'b0;
						run_left = $urandom_range(1, 8);
					end else if (r < 80) begin
						run_level = 1'b1;
						run_left = $urandom_range(1, 3);
					end else if (r < 95) begin
						run_level = 1'b0;
						run_left = $urandom_range(30, 150);
					end else begin
						run_level = 1'b1;
						run_left = $urandom_range(20, 60);
					end
				end
				run_left--;
				out_stall <= run_level;
			end
		end
	end

	always @(posedge clk) begin
		text_char_t want;
		if (arst_n && out_valid && !out_stall) begin
			chars_seen++;
			if (char_queue.size() == 0) begin
				report_mismatch($sformatf("unexpected character 0x%02h final %0b",
					character, final_char));
			end else begin
				want = char_queue.pop_front();
				if (character !== want.character)
					report_mismatch($sformatf("character 0x%02h, expected 0x%02h",
						character, want.character));
				if (final_char !== want.last)
					report_mismatch($sformatf("final_char %0b, expected %0b on 0x%02h",
						final_char, want.last, want.character));
			end
		end
	end

endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+design
design/sird_pkg.sv
design/sird_front.sv
design/sird_queue.sv
design/sird_back.sv
design/signed_int_to_radix_digits_unit.sv
design/sird_checker.sv
tb/sv/signed_int_to_radix_digits_unit_test.sv
